// ===== sv/named_semaphore_table_defines.svh =====
// ----------------------------------------------------------------------------
// named semaphore table assertion macros
// shared property forms for the semaphore table checks
// ----------------------------------------------------------------------------
`ifndef NAMED_SEMAPHORE_TABLE_DEFINES_SVH
`define NAMED_SEMAPHORE_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define NST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define NST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_pkg
// types and codes shared by the named semaphore table
// ----------------------------------------------------------------------------
package nst_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_OPEN   = 2'd0,
    OP_WAIT   = 2'd1,
    OP_POST   = 2'd2,
    OP_UNLINK = 2'd3
  } nst_op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXISTING   = 3'd1,
    ST_FULL       = 3'd2,
    ST_BLOCK      = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_BAD_HANDLE = 3'd5
  } nst_status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EXEC
  } nst_state_t;

  // top of the semaphore value and of the open count
  localparam logic signed [15:0] VAL_MAX = 16'sh7FFF;
  localparam logic [15:0]        CNT_MAX = 16'hFFFF;

  // input word
  typedef struct packed {
    nst_op_t     operation;
    logic [63:0] name_key;
    logic [14:0] initial_value;
    logic [2:0]  handle;
  } nst_in_t;

  // result word
  typedef struct packed {
    nst_status_t        status;
    logic [2:0]         result_handle;
    logic signed [15:0] value_after;
    logic               wake_request;
  } nst_out_t;

endpackage

// ===== sv/named_semaphore_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// named_semaphore_table
// table of named counting semaphores: open, wait, post and unlink
// ----------------------------------------------------------------------------
// Pulse start with a word while busy is low; exactly one result word comes
// back on out_word, marked by a single-cycle out_valid strobe that cannot be
// held off. Wait and post hold busy through the entry fetch and then the
// read-modify-write, and the result appears on the cycle after; a wait or
// post on a bad or free handle is answered the cycle after start with busy
// never raised. Open and unlink scan the key store one entry per cycle
// through its single read port: busy ends with the last compare when no
// live key matches, or runs on through fetch and update after a hit.
// All value and count arithmetic goes through one shared 16-bit
// increment/decrement unit.
module named_semaphore_table #(
  parameter int ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  nst_pkg::nst_in_t  in_word,
  output logic              out_valid,
  output nst_pkg::nst_out_t out_word
);
  import nst_pkg::*;

  localparam int               IW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0]      LAST_CNT = (IW + 1)'(ENTRIES);
  localparam logic [IW-1:0]    LAST_IDX = IW'(ENTRIES - 1);

  // control registers
  nst_state_t             state_r, state_nxt;
  logic [ENTRIES-1:0]     in_use_r, in_use_nxt;
  logic [IW:0]            scan_cnt_r, scan_cnt_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   free_vld_r, free_vld_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic [IW-1:0]          tgt_r, tgt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload registers
  nst_in_t                req_r, req_nxt;
  nst_out_t               out_word_r, out_word_nxt;

  // entry stores
  logic [63:0]            key_mem [ENTRIES];
  logic signed [15:0]     val_mem [ENTRIES];
  logic [15:0]            cnt_mem [ENTRIES];
  logic [63:0]            key_rd_r;
  logic signed [15:0]     val_rd_r;
  logic [15:0]            cnt_rd_r;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          wr_addr;
  logic                   key_we, val_we, cnt_we;
  logic signed [15:0]     val_wd;
  logic [15:0]            cnt_wd;

  // shared increment/decrement unit
  logic [15:0]            alu_a;
  logic                   alu_inc;
  logic [15:0]            alu_sum;

  // decode helpers
  logic                   start_ok;
  logic                   in_is_scan;
  logic [IW-1:0]          h_idx;
  logic                   h_bad;
  logic                   req_is_open;
  logic                   req_is_scan;
  logic                   cmp_live;
  logic                   hit;
  logic                   scan_last;
  logic                   free_now;
  logic [IW-1:0]          free_sel;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // incoming word checks
  assign start_ok   = start && !busy;
  assign in_is_scan = (in_word.operation == OP_OPEN) || (in_word.operation == OP_UNLINK);
  assign h_idx      = IW'(in_word.handle);
  assign h_bad      = (32'(in_word.handle) >= ENTRIES) || !in_use_r[h_idx];

  // scan compare on the word read out last cycle
  assign req_is_open = (req_r.operation == OP_OPEN);
  assign req_is_scan = req_is_open || (req_r.operation == OP_UNLINK);
  assign cmp_live    = in_use_r[cmp_idx_r];
  assign hit         = (state_r == S_SCAN) && cmp_vld_r && cmp_live &&
                       (key_rd_r == req_r.name_key);
  assign scan_last   = (state_r == S_SCAN) && cmp_vld_r && (cmp_idx_r == LAST_IDX) && !hit;
  assign free_now    = free_vld_r || (cmp_vld_r && !cmp_live);
  assign free_sel    = free_vld_r ? free_idx_r : cmp_idx_r;

  // shared unit: counts for open and unlink, values for wait and post
  assign alu_a   = req_is_scan ? cnt_rd_r : val_rd_r;
  assign alu_inc = req_is_open || (req_r.operation == OP_POST);
  assign alu_sum = alu_inc ? (alu_a + 16'd1) : (alu_a - 16'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_ok) begin
          if (in_is_scan) begin
            state_nxt = S_SCAN;
          end else if (!h_bad) begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_FETCH;
        end else if (scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    req_nxt       = req_r;
    in_use_nxt    = in_use_r;
    scan_cnt_nxt  = scan_cnt_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    rd_addr       = tgt_r;
    wr_addr       = tgt_r;
    key_we        = 1'b0;
    val_we        = 1'b0;
    cnt_we        = 1'b0;
    val_wd        = val_rd_r;
    cnt_wd        = cnt_rd_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_ok) begin
          req_nxt      = in_word;
          scan_cnt_nxt = '0;
          free_vld_nxt = 1'b0;
          tgt_nxt      = h_idx;
          // wait or post on a handle with no live entry
          if (!in_is_scan && h_bad) begin
            out_valid_nxt              = 1'b1;
            out_word_nxt.status        = ST_BAD_HANDLE;
            out_word_nxt.result_handle = in_word.handle;
            out_word_nxt.value_after   = '0;
            out_word_nxt.wake_request  = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // issue the next key read
        if (scan_cnt_r < LAST_CNT) begin
          rd_addr      = scan_cnt_r[IW-1:0];
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_cnt_r[IW-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        // remember the lowest free entry seen
        if (cmp_vld_r && !cmp_live && !free_vld_r) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (hit) begin
          cmp_vld_nxt = 1'b0;
          tgt_nxt     = cmp_idx_r;
        end else if (scan_last) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.wake_request = 1'b0;
          if (req_is_open && free_now) begin
            // claim the lowest free entry
            wr_addr                    = free_sel;
            key_we                     = 1'b1;
            val_we                     = 1'b1;
            cnt_we                     = 1'b1;
            val_wd                     = {1'b0, req_r.initial_value};
            cnt_wd                     = 16'd1;
            in_use_nxt[free_sel]       = 1'b1;
            out_word_nxt.status        = ST_OK;
            out_word_nxt.result_handle = 3'(free_sel);
            out_word_nxt.value_after   = {1'b0, req_r.initial_value};
          end else begin
            out_word_nxt.status        = req_is_open ? ST_FULL : ST_NOT_FOUND;
            out_word_nxt.result_handle = '0;
            out_word_nxt.value_after   = '0;
          end
        end
      end
      S_FETCH: begin
        rd_addr = tgt_r;
      end
      S_EXEC: begin
        // read-modify-write of the target entry
        out_valid_nxt              = 1'b1;
        out_word_nxt.result_handle = 3'(tgt_r);
        out_word_nxt.value_after   = val_rd_r;
        out_word_nxt.wake_request  = 1'b0;
        out_word_nxt.status        = ST_OK;
        case (req_r.operation)
          OP_OPEN: begin
            cnt_we              = 1'b1;
            cnt_wd              = (cnt_rd_r == CNT_MAX) ? cnt_rd_r : alu_sum;
            out_word_nxt.status = ST_EXISTING;
          end
          OP_UNLINK: begin
            cnt_we = 1'b1;
            cnt_wd = (cnt_rd_r != '0) ? alu_sum : '0;
            if (cnt_rd_r == 16'd1 || cnt_rd_r == '0) begin
              in_use_nxt[tgt_r] = 1'b0;
            end
          end
          OP_WAIT: begin
            if (val_rd_r > 16'sd0) begin
              val_we                   = 1'b1;
              val_wd                   = alu_sum;
              out_word_nxt.value_after = alu_sum;
            end else begin
              out_word_nxt.status = ST_BLOCK;
            end
          end
          default: begin
            // post saturates at the top value
            val_we                    = 1'b1;
            val_wd                    = (val_rd_r < VAL_MAX) ? alu_sum : val_rd_r;
            out_word_nxt.value_after  = (val_rd_r < VAL_MAX) ? alu_sum : val_rd_r;
            out_word_nxt.wake_request = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // entry stores, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= req_r.name_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_wd;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wd;
    end
    key_rd_r <= key_mem[rd_addr];
    val_rd_r <= val_mem[rd_addr];
    cnt_rd_r <= cnt_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      free_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      free_vld_r  <= free_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
    tgt_r      <= tgt_nxt;
    out_word_r <= out_word_nxt;
  end

  // checks
  `include "named_semaphore_table_defines.svh"

  // a result word only follows an accepted word or work in progress
  `NST_ASSERT_NOW(a_out_has_cause, clk, rst_n, out_valid_r, $past(busy || start), "result word without a request")

  // wake only on a successful post
  `NST_ASSERT_NOW(a_wake_ok, clk, rst_n, out_valid_r && out_word_r.wake_request, out_word_r.status == ST_OK, "wake request with non-ok status")

  // table full is only reported with every entry live
  `NST_ASSERT_NOW(a_full_all_live, clk, rst_n, out_valid_r && out_word_r.status == ST_FULL, &in_use_r, "table full with a free entry")

  // live bits change only at the end of a scan or in the update step
  `NST_ASSERT_NOW(a_live_change, clk, rst_n, !$stable(in_use_r), $past(state_r == S_SCAN || state_r == S_EXEC), "live bits changed outside an update")

  // a completed update always yields a result next cycle
  `NST_ASSERT_NEXT(a_exec_result, clk, rst_n, state_r == S_EXEC, out_valid_r && !busy, "update step produced no result")

endmodule

// ===== dv/semaphore_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_table_checker
// watches the command and result channels of the semaphore table, keeps its
// own copy of the table, works out the result word of every accepted command
// word and compares each result word, field by field, with the oldest one due
// ----------------------------------------------------------------------------
module semaphore_table_checker #(
  parameter int ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  nst_pkg::nst_in_t  in_word,
  input  logic              out_valid,
  input  nst_pkg::nst_out_t out_word,
  output int                mismatch_count,
  output int                results_due
);

  import nst_pkg::*;

  // shadow copy of the table
  logic [ENTRIES-1:0] live_mask;
  logic [63:0]        shadow_key   [ENTRIES];
  logic signed [15:0] shadow_value [ENTRIES];
  logic [15:0]        shadow_opens [ENTRIES];

  nst_out_t expected_results[$];
  nst_out_t due_word;

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // apply one command word to the shadow table and return its result word
  function automatic nst_out_t apply_semaphore_op(input nst_in_t w);
    nst_out_t r;
    int       hit;
    int       spare;
    int       h;
    r      = '0;
    r.status = ST_OK;
    hit    = -1;
    spare  = -1;
    h      = int'(w.handle);
    // lowest live entry with a matching name, and lowest free entry
    for (int i = 0; i < ENTRIES; i++) begin
      if (live_mask[i] && shadow_key[i] == w.name_key && hit < 0) hit = i;
      if (!live_mask[i] && spare < 0) spare = i;
    end
    case (w.operation)
      OP_OPEN: begin
        if (hit >= 0) begin
          if (shadow_opens[hit] != CNT_MAX) shadow_opens[hit] = shadow_opens[hit] + 16'd1;
          r.status        = ST_EXISTING;
          r.result_handle = 3'(hit);
          r.value_after   = shadow_value[hit];
        end else if (spare >= 0) begin
          shadow_key[spare]   = w.name_key;
          shadow_value[spare] = {1'b0, w.initial_value};
          shadow_opens[spare] = 16'd1;
          live_mask[spare]    = 1'b1;
          r.result_handle     = 3'(spare);
          r.value_after       = {1'b0, w.initial_value};
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_WAIT, OP_POST: begin
        if (h >= ENTRIES || !live_mask[h]) begin
          r.status        = ST_BAD_HANDLE;
          r.result_handle = w.handle;
        end else if (w.operation == OP_WAIT) begin
          // take a unit only when one is there
          r.result_handle = w.handle;
          if (shadow_value[h] > 0) begin
            shadow_value[h] = shadow_value[h] - 16'sd1;
          end else begin
            r.status = ST_BLOCK;
          end
          r.value_after = shadow_value[h];
        end else begin
          // post saturates at the top value and always asks for a wake-up
          if (shadow_value[h] != VAL_MAX) shadow_value[h] = shadow_value[h] + 16'sd1;
          r.result_handle = w.handle;
          r.value_after   = shadow_value[h];
          r.wake_request  = 1'b1;
        end
      end
      default: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (shadow_opens[hit] != 16'd0) shadow_opens[hit] = shadow_opens[hit] - 16'd1;
          if (shadow_opens[hit] == 16'd0) live_mask[hit] = 1'b0;
          r.result_handle = 3'(hit);
          r.value_after   = shadow_value[hit];
        end
      end
    endcase
    return r;
  endfunction

  // predict on accepted command words, compare on result strobes
  always @(posedge clk) begin
    if (!rst_n) begin
      live_mask = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_key[i]   = '0;
        shadow_value[i] = '0;
        shadow_opens[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (start && !busy) expected_results.push_back(apply_semaphore_op(in_word));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with none due", 64'(out_word), '0);
        end else begin
          due_word = expected_results.pop_front();
          if (out_word.status !== due_word.status)
            report_mismatch("status", 64'(out_word.status), 64'(due_word.status));
          if (out_word.result_handle !== due_word.result_handle)
            report_mismatch("result_handle", 64'(out_word.result_handle),
                            64'(due_word.result_handle));
          if (out_word.value_after !== due_word.value_after)
            report_mismatch("value_after", 64'(unsigned'(out_word.value_after)),
                            64'(unsigned'(due_word.value_after)));
          if (out_word.wake_request !== due_word.wake_request)
            report_mismatch("wake_request", 64'(out_word.wake_request),
                            64'(due_word.wake_request));
        end
      end
    end
    results_due <= expected_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives command words into the semaphore table: a directed pass over the
// edge cases, then random traffic over a small pool of names with random
// gaps; the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module testbench;

  import nst_pkg::*;

  localparam int ENTRIES      = 8;
  localparam int POOL_SIZE    = 12;
  localparam int RANDOM_WORDS = 1425;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  nst_in_t  in_word;
  logic     out_valid;
  nst_out_t out_word;
  int       mismatch_count;
  int       results_due;

  logic [63:0] name_pool [POOL_SIZE];
  bit          gaps_on;
  int          idle_cycles;

  named_semaphore_table #(.ENTRIES(ENTRIES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  semaphore_table_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_word       (out_word),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic nst_in_t make_word(input nst_op_t op, input logic [63:0] key,
                                        input logic [14:0] init, input logic [2:0] h);
    nst_in_t w;
    w.operation     = op;
    w.name_key      = key;
    w.initial_value = init;
    w.handle        = h;
    return w;
  endfunction

  // mostly short gaps, a few long ones, none while gaps are switched off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on) return 0;
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 9);
    return $urandom_range(20, 60);
  endfunction

  // hold the word until the block takes it, then idle for the gap
  task automatic send_word(input nst_in_t w, input int gap);
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      start   <= 1'b0;
      in_word <= make_word(nst_op_t'($urandom_range(0, 3)), {$urandom, $urandom},
                           15'($urandom), 3'($urandom));
    end
  endtask

  function automatic logic [14:0] pick_initial();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 15'd0;
    if (r < 3) return 15'h7FFF;
    if (r < 6) return 15'($urandom_range(1, 3));
    return 15'($urandom);
  endfunction

  function automatic nst_in_t random_word();
    logic [63:0] key;
    int          r;
    nst_op_t     op;
    r   = $urandom_range(0, 99);
    key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                      : name_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 28)      op = OP_OPEN;
    else if (r < 50) op = OP_WAIT;
    else if (r < 73) op = OP_POST;
    else             op = OP_UNLINK;
    return make_word(op, key, pick_initial(), 3'($urandom));
  endfunction

  // stimulus and verdict
  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    gaps_on = 1'b1;
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) name_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: free handles, unknown name, extremes of name and value
    send_word(make_word(OP_WAIT, '0, '0, 3'd0), pick_gap());
    send_word(make_word(OP_POST, '1, '1, 3'd7), pick_gap());
    send_word(make_word(OP_UNLINK, '1, '0, 3'd0), pick_gap());
    send_word(make_word(OP_OPEN, name_pool[0], 15'd0, 3'd0), pick_gap());
    send_word(make_word(OP_OPEN, name_pool[1], 15'h7FFF, 3'd0), pick_gap());
    send_word(make_word(OP_OPEN, name_pool[0], 15'h7FFF, 3'd5), pick_gap());
    // wait at zero blocks, post at the top saturates
    send_word(make_word(OP_WAIT, '0, '0, 3'd0), pick_gap());
    send_word(make_word(OP_POST, '0, '0, 3'd1), pick_gap());
    send_word(make_word(OP_WAIT, '0, '0, 3'd1), pick_gap());
    send_word(make_word(OP_POST, '0, '0, 3'd0), pick_gap());
    send_word(make_word(OP_WAIT, '0, '0, 3'd0), pick_gap());
    // fill the table, then one open too many
    for (int i = 2; i < 8; i++)
      send_word(make_word(OP_OPEN, name_pool[i], 15'(i * 1000), 3'd0), pick_gap());
    send_word(make_word(OP_OPEN, name_pool[8], 15'd5, 3'd0), pick_gap());
    // unlink lowers the count, frees at zero, then the freed entry is reused
    send_word(make_word(OP_UNLINK, name_pool[0], '0, 3'd0), pick_gap());
    send_word(make_word(OP_UNLINK, name_pool[0], '0, 3'd0), pick_gap());
    send_word(make_word(OP_WAIT, '0, '0, 3'd0), pick_gap());
    send_word(make_word(OP_OPEN, name_pool[8], 15'd5, 3'd0), pick_gap());
    send_word(make_word(OP_UNLINK, name_pool[8], '0, 3'd0), pick_gap());

    // random traffic, idling switched off for some stretches
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_word(random_word(), pick_gap());
    end

    // drain and settle
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/nst_pkg.sv
sv/named_semaphore_table.sv
dv/semaphore_table_checker.sv
dv/testbench.sv
